FILE: hw/rtl/modulus_block_cipher_assert.svh
// Assertion macros for the modulus block cipher.
// Each use names a label, an antecedent and a consequent; clock and reset
// are the top level's aclk and aresetn.
`ifndef MODULUS_BLOCK_CIPHER_ASSERT_SVH
`define MODULUS_BLOCK_CIPHER_ASSERT_SVH
`ifndef SYNTH
`define MBC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("modulus_block_cipher: same-cycle check failed");
`define MBC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("modulus_block_cipher: next-cycle check failed");
`else
`define MBC_ASSERT_IMP(lbl, ante, cons)
`define MBC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/mbc_pkg.sv
`default_nettype none
package mbc_pkg;

    localparam logic KIND_ENC = 1'b0;
    localparam logic KIND_DEC = 1'b1;

    localparam logic REG_KEY_SET = 1'b0;

    localparam int NUM_WORDS  = 4;
    localparam int MUL_STEP   = 16;              // first cell of each word multiplies
    localparam int WORD_CELLS = MUL_STEP + 1;    // multiply plus 16 reduce steps
    localparam int NUM_CELLS  = NUM_WORDS * WORD_CELLS;

    localparam logic [7:0] CS_SEED  = 8'hF8;
    localparam logic [7:0] TAIL_XOR = 8'h3D;

    localparam logic [17:0] KEY_MOD [0:1][0:3] = '{
        '{18'h1F44F, 18'h28386, 18'h1125B, 18'h1A192},
        '{18'h11E6E, 18'h1ADA5, 18'h1821B, 18'h29C32}
    };
    localparam logic [15:0] KEY_ENC [0:1][0:3] = '{
        '{16'h5BC1, 16'h2E87, 16'h4D68, 16'h354F},
        '{16'h3371, 16'h4A5C, 16'h8A9A, 16'h7393}
    };
    localparam logic [15:0] KEY_DEC [0:1][0:3] = '{
        '{16'h7B38, 16'h07FF, 16'hDEB3, 16'h27C7},
        '{16'h4673, 16'h7684, 16'h607D, 16'h2B85}
    };
    localparam logic [15:0] KEY_XK [0:1][0:3] = '{
        '{16'hBD1D, 16'hB455, 16'h3B43, 16'h9239},
        '{16'hF234, 16'hFB99, 16'h8A2E, 16'hFC57}
    };

    // tag_a: checksum (encrypt) or size byte (decrypt)
    // tag_b: size tail byte (encrypt) or received checksum byte (decrypt)
    typedef struct packed {
        logic             kind;
        logic [7:0]       tag_a;
        logic [7:0]       tag_b;
        logic [3:0][17:0] vals;
        logic [3:0][17:0] res;
        logic [31:0]      acc;
    } item_t;

endpackage
`default_nettype wire

FILE: hw/rtl/mbc_front.sv
`default_nettype none
module mbc_front (
    input  logic          kind,
    input  logic [63:0]   data_low,
    input  logic [23:0]   data_high,
    input  logic [3:0]    valid_bytes,
    input  logic          key_set,
    output mbc_pkg::item_t item
);
    import mbc_pkg::*;

    logic [10:0][7:0] blk;
    logic [71:0]      stream;
    logic [3:0][17:0] unp;
    logic [3:0][17:0] unch;
    logic [7:0]       cs;

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            blk[j] = data_low[8*j +: 8];
        end
        blk[8]  = data_high[7:0];
        blk[9]  = data_high[15:8];
        blk[10] = data_high[23:16];

        // bytes are filled MSB first
        for (int j = 0; j < 9; j++) begin
            stream[71 - 8*j -: 8] = blk[j];
        end
        for (int i = 0; i < NUM_WORDS; i++) begin
            unp[i] = {stream[71 - 18*i - 16 -: 2], stream[71 - 18*i - 8 -: 8],
                      stream[71 - 18*i -: 8]};
        end

        // undo the xor chain from the top word down
        unch[3] = unp[3];
        for (int i = 2; i >= 0; i--) begin
            unch[i] = unp[i] ^ {2'b00, KEY_XK[key_set][i] ^ unch[i+1][15:0]};
        end

        cs = CS_SEED;
        for (int j = 0; j < 8; j++) begin
            cs = cs ^ blk[j];
        end

        item      = '0;
        item.kind = kind;
        if (kind == KIND_DEC) begin
            item.vals  = unch;
            item.tag_a = blk[9] ^ blk[10] ^ TAIL_XOR;
            item.tag_b = blk[10];
        end else begin
            for (int i = 0; i < NUM_WORDS; i++) begin
                item.vals[i] = {2'b00, data_low[16*i +: 16]};
            end
            item.tag_a = cs;
            item.tag_b = cs ^ {4'h0, valid_bytes} ^ TAIL_XOR;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/mbc_cell.sv
`default_nettype none
module mbc_cell #(
    parameter int WORD = 0,
    parameter int STEP = 0
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           adv,
    input  logic           key_set,
    input  logic           in_valid,
    input  mbc_pkg::item_t in_item,
    output logic           out_valid,
    output mbc_pkg::item_t out_item
);
    import mbc_pkg::*;

    localparam logic [1:0] W  = 2'(WORD);
    localparam logic [1:0] PW = (WORD == 0) ? 2'd0 : 2'(WORD - 1);

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;

    if (STEP == MUL_STEP) begin : g_mul
        logic [15:0] prev_w;
        logic [17:0] operand;
        logic [15:0] mult;
        logic [33:0] prod;

        always_comb begin
            prev_w = (WORD == 0) ? 16'h0000 : in_item.res[PW][15:0];
            if (in_item.kind == KIND_DEC) begin
                operand = in_item.vals[W];
                mult    = KEY_DEC[key_set][W];
            end else begin
                operand = {2'b00, KEY_XK[key_set][W] ^ in_item.vals[W][15:0] ^ prev_w};
                mult    = KEY_ENC[key_set][W];
            end
            prod          = {16'h0000, operand} * {18'h00000, mult};
            item_next     = in_item;
            item_next.acc = prod[31:0];
        end
    end else begin : g_red
        logic [32:0] m_sh;
        logic [15:0] prev_d;

        always_comb begin
            m_sh      = {15'h0000, KEY_MOD[key_set][W]} << STEP;
            prev_d    = (WORD == 0) ? 16'h0000 : in_item.vals[PW][15:0];
            item_next = in_item;
            if ({1'b0, in_item.acc} >= m_sh) begin
                item_next.acc = in_item.acc - m_sh[31:0];
            end
            if (STEP == 0) begin
                if (in_item.kind == KIND_DEC) begin
                    item_next.res[W] = {2'b00,
                        item_next.acc[15:0] ^ KEY_XK[key_set][W] ^ prev_d};
                end else begin
                    item_next.res[W] = item_next.acc[17:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/mbc_back.sv
`default_nettype none
module mbc_back (
    input  mbc_pkg::item_t item,
    input  logic           key_set,
    output logic [63:0]    out_low,
    output logic [23:0]    out_high,
    output logic [7:0]     decoded_size,
    output logic           checksum_ok
);
    import mbc_pkg::*;

    logic [3:0][17:0] c;
    logic [71:0]      stream;
    logic [8:0][7:0]  cb;
    logic [63:0]      plain;
    logic [7:0]       cs;

    always_comb begin
        // fold the next word back into each lower one
        c[3] = item.res[3];
        for (int i = 0; i < 3; i++) begin
            c[i] = item.res[i] ^ {2'b00, KEY_XK[key_set][i] ^ item.res[i+1][15:0]};
        end
        for (int i = 0; i < NUM_WORDS; i++) begin
            stream[71 - 18*i -: 18] = {c[i][7:0], c[i][15:8], c[i][17:16]};
        end
        for (int j = 0; j < 9; j++) begin
            cb[j] = stream[71 - 8*j -: 8];
        end

        for (int i = 0; i < NUM_WORDS; i++) begin
            plain[16*i +: 16] = item.res[i][15:0];
        end
        cs = CS_SEED;
        for (int j = 0; j < 8; j++) begin
            cs = cs ^ plain[8*j +: 8];
        end

        if (item.kind == KIND_DEC) begin
            out_low      = plain;
            out_high     = 24'h000000;
            decoded_size = item.tag_a;
            checksum_ok  = (cs == item.tag_b);
        end else begin
            for (int j = 0; j < 8; j++) begin
                out_low[8*j +: 8] = cb[j];
            end
            out_high     = {item.tag_a, item.tag_b, cb[8]};
            decoded_size = 8'h00;
            checksum_ok  = 1'b1;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/modulus_block_cipher.sv
// Modulus block cipher: 8 plain bytes <-> 11 cipher bytes, one block a beat.
//
// Input channel (s_*): kind selects encrypt (0) or decrypt (1); data_low holds
// bytes 0..7, data_high bytes 8..10 of a cipher block (decrypt only), and
// valid_bytes is folded into the size tail on encrypt.
// Result channel (m_*): one result beat per input beat, in order. Encrypt
// gives the 11 cipher bytes; decrypt gives the 8 plain bytes, the recovered
// size byte and a checksum flag.
// Configuration: APB register 0 (byte address 0), key_set, picks one of two
// built-in key sets. Write it only while no block is in flight.
//
// Throughput is one block per cycle while the result channel does not stall.
// Between the input beat and the result lie 68 cells (four words, each a
// multiply cell and 16 restoring reduce cells) and the output register. The
// encrypt chain through the four words sets the cell count.
// Reset clears key_set to 0 and drops every block in flight. While the
// receiver stalls, the result holds in the output register and the chain
// keeps moving until a finished block reaches its end; then s_ready drops.
`default_nettype none
`include "modulus_block_cipher_assert.svh"
module modulus_block_cipher (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [63:0] s_data_low,
    input  logic [23:0] s_data_high,
    input  logic [3:0]  s_valid_bytes,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_out_low,
    output logic [23:0] m_out_high,
    output logic [7:0]  m_decoded_size,
    output logic        m_checksum_ok
);
    import mbc_pkg::*;

    logic key_set_reg;
    logic key_set_next;
    logic reg_idx;

    // APB: register index is the word address
    assign reg_idx = paddr[2];
    assign pready  = 1'b1;
    assign prdata  = (reg_idx == REG_KEY_SET) ? {31'h0, key_set_reg} : 32'h0;

    always_comb begin
        key_set_next = key_set_reg;
        if (psel && penable && pwrite && reg_idx == REG_KEY_SET) begin
            key_set_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_set_reg <= 1'b0;
        end else begin
            key_set_reg <= key_set_next;
        end
    end

    // Cell chain: stage 0 is the unpacked input beat, stage NUM_CELLS the last
    item_t stage_item  [0:NUM_CELLS];
    logic  stage_valid [0:NUM_CELLS];
    logic  adv;
    logic  m_valid_reg;
    logic  m_valid_next;

    // advance the whole chain unless a finished block would be blocked
    assign adv     = !stage_valid[NUM_CELLS] || !m_valid_reg || m_ready;
    assign s_ready = adv;

    mbc_front u_front (
        .kind        (s_kind),
        .data_low    (s_data_low),
        .data_high   (s_data_high),
        .valid_bytes (s_valid_bytes),
        .key_set     (key_set_reg),
        .item        (stage_item[0])
    );
    assign stage_valid[0] = s_valid;

    for (genvar n = 0; n < NUM_CELLS; n++) begin : g_cell
        mbc_cell #(
            .WORD (n / WORD_CELLS),
            .STEP (MUL_STEP - (n % WORD_CELLS))
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .key_set   (key_set_reg),
            .in_valid  (stage_valid[n]),
            .in_item   (stage_item[n]),
            .out_valid (stage_valid[n+1]),
            .out_item  (stage_item[n+1])
        );
    end

    // Pack the finished block into result fields
    logic [63:0] fin_low;
    logic [23:0] fin_high;
    logic [7:0]  fin_size;
    logic        fin_ok;

    mbc_back u_back (
        .item         (stage_item[NUM_CELLS]),
        .key_set      (key_set_reg),
        .out_low      (fin_low),
        .out_high     (fin_high),
        .decoded_size (fin_size),
        .checksum_ok  (fin_ok)
    );

    // Output register: hold the result beat until taken
    logic [63:0] m_low_reg;
    logic [23:0] m_high_reg;
    logic [7:0]  m_size_reg;
    logic        m_ok_reg;
    logic        load;

    assign load = adv && stage_valid[NUM_CELLS];

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_low_reg  <= fin_low;
            m_high_reg <= fin_high;
            m_size_reg <= fin_size;
            m_ok_reg   <= fin_ok;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_low      = m_low_reg;
    assign m_out_high     = m_high_reg;
    assign m_decoded_size = m_size_reg;
    assign m_checksum_ok  = m_ok_reg;

    // an empty output register never blocks the input
    `MBC_ASSERT_IMP(a_ready_when_empty, !m_valid_reg, s_ready)
    // a block leaving the chain always lands in the output register
    `MBC_ASSERT_NXT(a_load_lands, load, m_valid_reg)
    // a failed checksum only comes from a decrypt, whose high bytes are zero
    `MBC_ASSERT_IMP(a_bad_cs_is_dec, m_valid_reg && !m_ok_reg, m_high_reg == 24'h000000)

endmodule
`default_nettype wire

FILE: tb/mbc_checker.sv
module mbc_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        key_sel,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_kind,
    input  logic [63:0] s_data_low,
    input  logic [23:0] s_data_high,
    input  logic [3:0]  s_valid_bytes,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [63:0] m_out_low,
    input  logic [23:0] m_out_high,
    input  logic [7:0]  m_decoded_size,
    input  logic        m_checksum_ok,
    output int          fail_count,
    output int          blocks_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mbc_pkg::*;

    typedef struct {
        logic [63:0] lo;
        logic [23:0] hi;
        logic [7:0]  size;
        logic        ok;
    } cipher_result_t;

    cipher_result_t block_queue[$];

    // put one bit into the 88-bit stream, MSB first within each byte
    function automatic void set_stream_bit(ref logic [7:0] blk[11], input int p,
                                           input logic b);
        blk[(p >> 3) % 11][7 - (p & 7)] = b;
    endfunction

    function automatic cipher_result_t cipher_block(logic ks, logic kind,
            logic [63:0] lo, logic [23:0] hi, logic [3:0] vb);
        cipher_result_t r;
        logic [7:0]  blk[11];
        logic [31:0] v[4];
        logic [31:0] prev, prod, t;
        logic [17:0] chunk;
        logic [7:0]  cs;
        logic [63:0] plain;
        r = '{lo: '0, hi: '0, size: '0, ok: 1'b1};
        prev = 0;
        cs = CS_SEED;
        foreach (blk[i]) blk[i] = 8'h00;
        if (kind == KIND_ENC) begin
            for (int i = 0; i < 4; i++) begin
                prod = ({16'h0, KEY_XK[ks][i]} ^ {16'h0, lo[16*i +: 16]} ^ prev)
                       * {16'h0, KEY_ENC[ks][i]};
                v[i] = prod % {14'h0, KEY_MOD[ks][i]};
                prev = v[i] & 32'hFFFF;
            end
            for (int i = 0; i < 3; i++)
                v[i] = v[i] ^ {16'h0, KEY_XK[ks][i]} ^ (v[i+1] & 32'hFFFF);
            for (int i = 0; i < 4; i++) begin
                chunk = {v[i][7:0], v[i][15:8], v[i][17:16]};
                for (int k = 0; k < 18; k++)
                    set_stream_bit(blk, 18*i + k, chunk[17-k]);
            end
            for (int i = 0; i < 8; i++) cs ^= lo[8*i +: 8];
            blk[9]  = cs ^ {4'h0, vb} ^ TAIL_XOR;
            blk[10] = cs;
            for (int i = 0; i < 8; i++) r.lo[8*i +: 8] = blk[i];
            r.hi = {blk[10], blk[9], blk[8]};
        end else begin
            for (int i = 0; i < 8; i++) blk[i] = lo[8*i +: 8];
            for (int i = 0; i < 3; i++) blk[8+i] = hi[8*i +: 8];
            for (int i = 0; i < 4; i++) begin
                for (int k = 0; k < 18; k++) begin
                    int p;
                    p = 18*i + k;
                    chunk[17-k] = blk[(p >> 3) % 11][7 - (p & 7)];
                end
                v[i] = {14'h0, chunk[1:0], chunk[9:2], chunk[17:10]};
            end
            for (int i = 2; i >= 0; i--)
                v[i] = v[i] ^ {16'h0, KEY_XK[ks][i]} ^ (v[i+1] & 32'hFFFF);
            plain = '0;
            for (int i = 0; i < 4; i++) begin
                prod = {16'h0, KEY_DEC[ks][i]} * v[i];
                t = (prod % {14'h0, KEY_MOD[ks][i]}) ^ {16'h0, KEY_XK[ks][i]} ^ prev;
                prev = v[i] & 32'hFFFF;
                plain[16*i +: 16] = t[15:0];
            end
            for (int i = 0; i < 8; i++) cs ^= plain[8*i +: 8];
            r.lo = plain;
            r.size = blk[9] ^ blk[10] ^ TAIL_XOR;
            r.ok = (cs == blk[10]);
        end
        return r;
    endfunction

    assign blocks_pending = block_queue.size();

    always @(posedge aclk) begin
        cipher_result_t want;
        if (aresetn && s_valid && s_ready)
            block_queue.push_back(cipher_block(key_sel, s_kind, s_data_low,
                                               s_data_high, s_valid_bytes));
        if (aresetn && m_valid && m_ready) begin
            if (block_queue.size() == 0) begin
                $error("result beat with nothing expected");
                fail_count++;
            end else begin
                want = block_queue.pop_front();
                if (m_out_low !== want.lo) begin
                    $error("out_low exp %h got %h", want.lo, m_out_low);
                    fail_count++;
                end
                if (m_out_high !== want.hi) begin
                    $error("out_high exp %h got %h", want.hi, m_out_high);
                    fail_count++;
                end
                if (m_decoded_size !== want.size) begin
                    $error("decoded_size exp %h got %h", want.size, m_decoded_size);
                    fail_count++;
                end
                if (m_checksum_ok !== want.ok) begin
                    $error("checksum_ok exp %b got %b", want.ok, m_checksum_ok);
                    fail_count++;
                end
            end
        end
    end
endmodule

FILE: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mbc_pkg::*;

    localparam int LATENCY     = 69;
    localparam int CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0, s_ready;
    logic        s_kind = KIND_ENC;
    logic [63:0] s_data_low = '0;
    logic [23:0] s_data_high = '0;
    logic [3:0]  s_valid_bytes = '0;
    logic        m_valid, m_ready = 1'b0;
    logic [63:0] m_out_low;
    logic [23:0] m_out_high;
    logic [7:0]  m_decoded_size;
    logic        m_checksum_ok;

    // shadow of the key_set register, read by the checker at each input beat
    logic        key_sel = 1'b0;
    int          fail_count, blocks_pending;
    int          send_idle_pct = 0;   // sender idle chance, percent
    int          recv_stall_pct = 0;  // receiver stall chance, percent
    logic        hold_req = 1'b0;     // ask for one long receiver hold-off
    logic        hold_taken = 1'b0;
    int          hold_off = 0;        // long receiver hold-off, in cycles
    int          cycle_count = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    modulus_block_cipher dut (.*);

    mbc_checker u_checker (.*);

    // Cycle limit: give up on a hung block.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Receiver: stall at random, or hold off entirely for a long stretch
    // counted here, so the pipeline fills and s_ready drops.
    always @(posedge aclk) begin
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_off   <= 300;
            m_ready    <= 1'b0;
        end else if (hold_off > 0) begin
            m_ready  <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Write one register through the APB port: setup cycle, then access.
    task automatic write_key_set(input logic val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {2'b00, REG_KEY_SET} << 2;
        pwdata  <= {31'h0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        key_sel <= val;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Offer one beat and hold it until accepted; idle gaps go before it.
    task automatic send_block(input logic kind, input logic [63:0] lo,
                              input logic [23:0] hi, input logic [3:0] vb);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_data_low    <= lo;
        s_data_high   <= hi;
        s_valid_bytes <= vb;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (blocks_pending != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    // Random blocks of either kind; now and then the plain bytes are masked
    // to all zero so that flat blocks also come through.
    task automatic random_blocks(input int count);
        logic [63:0] lo;
        logic [23:0] hi;
        for (int n = 0; n < count; n++) begin
            lo = {$urandom, $urandom};
            hi = 24'($urandom);
            if ($urandom_range(3) == 0)
                lo = lo & {8{8'($urandom_range(1) ? 8'hFF : 8'h00)}};
            send_block(1'($urandom_range(1)), lo, hi, 4'($urandom_range(15)));
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, both kinds, odd sizes, bad checksums.
        send_block(KIND_ENC, 64'h0, 24'h0, 4'd8);
        send_block(KIND_ENC, '1, '1, 4'd1);
        send_block(KIND_ENC, 64'h0011223344556677, 24'hABCDEF, 4'd0);
        send_block(KIND_ENC, 64'h8000800080008000, 24'h0, 4'd15);
        send_block(KIND_ENC, 64'h0000000000000041, 24'h0, 4'd1);
        send_block(KIND_DEC, 64'h0, 24'h0, 4'd0);
        send_block(KIND_DEC, '1, '1, 4'd15);
        send_block(KIND_DEC, 64'h5555AAAA5555AAAA, 24'hF83D00, 4'd8);
        send_block(KIND_DEC, 64'h0123456789ABCDEF, 24'h00FFC5, 4'd3);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            // Alternate key sets, extremes included.
            write_key_set(phase[0]);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            if (phase == 4) hold_req = 1'b1;
            random_blocks(220);
            drain();
        end

        if (fail_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
